>>> rtl/tlbl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the two-level token bucket limiter.
package tlbl_pkg;

	localparam int NUM_CLIENTS_DEF = 64;

	localparam int CMD_W        = 3;
	localparam int CLIENT_IDX_W = 6;
	localparam int TOKEN_W      = 16;
	localparam int SEC_W        = 32;
	localparam int PROD_W       = TOKEN_W + SEC_W;
	localparam int STATUS_W     = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// commands
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SWEEP   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_GLOBAL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_CLIENT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BURST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_RATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_BURST  = 3'd5;

	// register reset values
	localparam logic [TOKEN_W-1:0] RST_DEFAULT_RATE  = 16'd100;
	localparam logic [TOKEN_W-1:0] RST_DEFAULT_BURST = 16'd20;
	localparam logic [TOKEN_W-1:0] RST_WINDOW        = 16'd60;
	localparam logic [TOKEN_W-1:0] RST_GLOBAL_RATE   = 16'd1000;
	localparam logic [TOKEN_W-1:0] RST_GLOBAL_BURST  = 16'd200;

	localparam logic [TOKEN_W-1:0] CONN_MAX = 16'hFFFF;

	typedef struct packed {
		logic               enable;
		logic [TOKEN_W-1:0] default_rate;
		logic [TOKEN_W-1:0] default_burst;
		logic [TOKEN_W-1:0] window_seconds;
		logic [TOKEN_W-1:0] global_rate;
		logic [TOKEN_W-1:0] global_burst;
		logic               global_burst_wr;
		logic [TOKEN_W-1:0] global_burst_wdata;
	} cfg_t;

	// one client table entry
	typedef struct packed {
		logic [TOKEN_W-1:0] rate;
		logic [TOKEN_W-1:0] burst;
		logic [TOKEN_W-1:0] tokens;
		logic [SEC_W-1:0]   last_second;
		logic [TOKEN_W-1:0] connections;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                allowed;
		logic [STATUS_W-1:0] status;
		logic [TOKEN_W-1:0]  remaining;
		logic [TOKEN_W-1:0]  reset_after;
		logic                connection_ok;
		logic [TOKEN_W-1:0]  active_connections;
	} res_t;

endpackage

>>> rtl/tlbl_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: one word is one command with its operands.
interface tlbl_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [5:0]  client_index;
	logic        use_default;
	logic [15:0] req_rate;
	logic [15:0] req_burst;
	logic [15:0] max_connections;

	modport source (
		output valid, command, client_index, use_default, req_rate, req_burst,
		       max_connections,
		input  ready
	);
	modport sink (
		input  valid, command, client_index, use_default, req_rate, req_burst,
		       max_connections,
		output ready
	);
endinterface

>>> rtl/tlbl_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one word is the result of one command.
interface tlbl_rsp_if;
	logic        valid;
	logic        ready;
	logic        allowed;
	logic [1:0]  status;
	logic [15:0] remaining;
	logic [15:0] reset_after;
	logic        connection_ok;
	logic [15:0] active_connections;

	modport source (
		output valid, allowed, status, remaining, reset_after, connection_ok,
		       active_connections,
		input  ready
	);
	modport sink (
		input  valid, allowed, status, remaining, reset_after, connection_ok,
		       active_connections,
		output ready
	);
endinterface

>>> rtl/tlbl_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read per cycle.
module tlbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/tlbl_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the limiter.
module tlbl_regs import tlbl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);
	logic               enable_q;
	logic [TOKEN_W-1:0] default_rate_q;
	logic [TOKEN_W-1:0] default_burst_q;
	logic [TOKEN_W-1:0] window_q;
	logic [TOKEN_W-1:0] global_rate_q;
	logic [TOKEN_W-1:0] global_burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			default_rate_q  <= RST_DEFAULT_RATE;
			default_burst_q <= RST_DEFAULT_BURST;
			window_q        <= RST_WINDOW;
			global_rate_q   <= RST_GLOBAL_RATE;
			global_burst_q  <= RST_GLOBAL_BURST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:        enable_q        <= cfg_wdata[0];
				REG_DEFAULT_RATE:  default_rate_q  <= cfg_wdata;
				REG_DEFAULT_BURST: default_burst_q <= cfg_wdata;
				REG_WINDOW:        window_q        <= cfg_wdata;
				REG_GLOBAL_RATE:   global_rate_q   <= cfg_wdata;
				REG_GLOBAL_BURST:  global_burst_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.enable             = enable_q;
		cfg.default_rate       = default_rate_q;
		cfg.default_burst      = default_burst_q;
		cfg.window_seconds     = window_q;
		cfg.global_rate        = global_rate_q;
		cfg.global_burst       = global_burst_q;
		// a global_burst write also reloads the global bucket
		cfg.global_burst_wr    = cfg_we && (cfg_index == REG_GLOBAL_BURST);
		cfg.global_burst_wdata = cfg_wdata;
	end
endmodule

>>> rtl/tlbl_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer with global bucket and read-modify-write of the client table.
module tlbl_ctrl import tlbl_pkg::*; #(
	parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tlbl_cmd_if.sink      cmd,
	input  cfg_t          cfg,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res
);
	localparam int IDX_W = $clog2(NUM_CLIENTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);
	localparam bit WIDE_TABLE = NUM_CLIENTS >= (1 << CLIENT_IDX_W);
	localparam logic [CLIENT_IDX_W:0] NC_NARROW = (CLIENT_IDX_W + 1)'(NUM_CLIENTS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_CLIENT = 3'd3;
	localparam logic [2:0] ST_SWEEP  = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	// control state
	logic [2:0]         state_q, state_d;
	logic [SEC_W-1:0]   seconds_q, seconds_d;
	logic [TOKEN_W-1:0] gtok_q, gtok_d;
	logic [SEC_W-1:0]   glast_q, glast_d;
	logic [IDX_W-1:0]   sw_addr_q, sw_addr_d;
	logic               sw_issue_q, sw_issue_d;
	logic               sw_v_s1, sw_v_d;

	// payload
	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TOKEN_W-1:0] rate_q;
	logic [TOKEN_W-1:0] burst_q;
	logic [TOKEN_W-1:0] maxc_q;
	logic [PROD_W-1:0]  g_prod_s1;
	logic               g_elnz_s1;
	entry_t             ent_s2, ent_d;
	logic [PROD_W-1:0]  c_prod_s2, c_prod_d;
	logic               c_elnz_s2, c_elnz_d;
	logic [IDX_W-1:0]   sw_addr_s1;
	res_t               res_q, res_d;

	// datapath
	logic                  cmd_fire;
	logic [CLIENT_IDX_W:0] rem;
	logic [IDX_W-1:0]      idx_in;
	logic [SEC_W-1:0]      g_el;
	logic [PROD_W-1:0]     g_prod;
	logic [PROD_W:0]       g_sum;
	logic [TOKEN_W-1:0]    g_new;
	entry_t                rd_ent;
	entry_t                ent_m;
	logic                  mismatch;
	logic [SEC_W-1:0]      c_el;
	logic [PROD_W-1:0]     c_prod;
	logic [PROD_W:0]       c_sum;
	logic [TOKEN_W-1:0]    c_new;
	entry_t                ent_w;
	logic [SEC_W-1:0]      sw_el;
	logic                  expire;
	logic [TOKEN_W-1:0]    conn_up;
	logic [TOKEN_W-1:0]    conn_dn;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;

	tlbl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_CLIENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// client index modulo table size, one restoring step per index bit
	always_comb begin
		rem = '0;
		for (int i = CLIENT_IDX_W - 1; i >= 0; i--) begin
			rem = {rem[CLIENT_IDX_W-1:0], cmd.client_index[i]};
			if (rem >= NC_NARROW) begin
				rem = rem - NC_NARROW;
			end
		end
		if (WIDE_TABLE) begin
			idx_in = IDX_W'(cmd.client_index);
		end else begin
			idx_in = IDX_W'(rem);
		end
	end

	always_comb begin
		g_el   = seconds_q - glast_q;
		g_prod = cfg.global_rate * g_el;
		g_sum  = {1'b0, g_prod_s1} + (PROD_W + 1)'(gtok_q);
		if (!g_elnz_s1) begin
			g_new = gtok_q;
		end else if (g_sum > (PROD_W + 1)'(cfg.global_burst)) begin
			g_new = cfg.global_burst;
		end else begin
			g_new = g_sum[TOKEN_W-1:0];
		end

		rd_ent   = entry_t'(ram_rdata);
		mismatch = (rd_ent.rate != rate_q) || (rd_ent.burst != burst_q);
		ent_m    = rd_ent;
		// new rate or burst: reload the entry, no refill this time
		if (mismatch) begin
			ent_m.rate        = rate_q;
			ent_m.burst       = burst_q;
			ent_m.tokens      = burst_q;
			ent_m.last_second = seconds_q;
		end
		c_el   = seconds_q - ent_m.last_second;
		c_prod = rate_q * c_el;

		c_sum = {1'b0, c_prod_s2} + (PROD_W + 1)'(ent_s2.tokens);
		if (!c_elnz_s2) begin
			c_new = ent_s2.tokens;
		end else if (c_sum > (PROD_W + 1)'(ent_s2.burst)) begin
			c_new = ent_s2.burst;
		end else begin
			c_new = c_sum[TOKEN_W-1:0];
		end

		sw_el  = seconds_q - rd_ent.last_second;
		expire = sw_el > SEC_W'({cfg.window_seconds, 1'b0});

		conn_up = (rd_ent.connections != CONN_MAX) ? rd_ent.connections + 16'd1
		                                          : rd_ent.connections;
		conn_dn = (rd_ent.connections != '0) ? rd_ent.connections - 16'd1
		                                     : rd_ent.connections;
	end

	always_comb begin
		state_d    = state_q;
		seconds_d  = seconds_q;
		gtok_d     = gtok_q;
		glast_d    = glast_q;
		sw_addr_d  = sw_addr_q;
		sw_issue_d = sw_issue_q;
		sw_v_d     = 1'b0;
		res_d      = res_q;
		ent_d      = ent_s2;
		c_prod_d   = c_prod_s2;
		c_elnz_d   = c_elnz_s2;
		ent_w      = ent_s2;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = '0;
		ram_raddr  = idx_q;

		case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sw_addr_q;
				if (sw_addr_q == LAST_IDX) begin
					sw_addr_d = '0;
					state_d   = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end else begin
					sw_addr_d = sw_addr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				ram_raddr = idx_in;
				if (cmd_fire) begin
					res_d = '0;
					case (cmd.command)
						CMD_TICK: begin
							seconds_d = seconds_q + 1'b1;
							state_d   = ST_EVAL;
						end
						CMD_SWEEP: begin
							sw_addr_d  = '0;
							sw_issue_d = 1'b1;
							state_d    = ST_SWEEP;
						end
						CMD_CLEAR: begin
							sw_addr_d = '0;
							gtok_d    = cfg.global_burst;
							glast_d   = seconds_q;
							state_d   = ST_CLEAR;
						end
						default: state_d = ST_EVAL;
					endcase
				end
			end
			ST_EVAL: begin
				res_d.active_connections = rd_ent.connections;
				state_d = ST_DONE;
				case (cmd_q)
					CMD_REQUEST: begin
						if (!cfg.enable) begin
							res_d.allowed = 1'b1;
						end else begin
							res_d.reset_after = cfg.window_seconds;
							if (g_elnz_s1) begin
								glast_d = seconds_q;
							end
							if (g_new == '0) begin
								gtok_d       = '0;
								res_d.status = STAT_GLOBAL;
							end else begin
								gtok_d   = g_new - 1'b1;
								ent_d    = ent_m;
								c_prod_d = c_prod;
								c_elnz_d = (c_el != '0);
								state_d  = ST_CLIENT;
							end
						end
					end
					CMD_CHECK: begin
						res_d.connection_ok = !cfg.enable || (rd_ent.connections < maxc_q);
					end
					CMD_OPEN: begin
						ent_w             = rd_ent;
						ent_w.connections = conn_up;
						ram_we            = 1'b1;
						ram_wdata         = ent_w;
						res_d.active_connections = conn_up;
					end
					CMD_CLOSE: begin
						ent_w             = rd_ent;
						ent_w.connections = conn_dn;
						ram_we            = 1'b1;
						ram_wdata         = ent_w;
						res_d.active_connections = conn_dn;
					end
					default: ;
				endcase
			end
			ST_CLIENT: begin
				ent_w = ent_s2;
				if (c_elnz_s2) begin
					ent_w.last_second = seconds_q;
				end
				if (c_new == '0) begin
					ent_w.tokens    = '0;
					res_d.status    = STAT_CLIENT;
					res_d.remaining = '0;
				end else begin
					ent_w.tokens    = c_new - 1'b1;
					res_d.allowed   = 1'b1;
					res_d.remaining = c_new - 1'b1;
				end
				ram_we    = 1'b1;
				ram_wdata = ent_w;
				state_d   = ST_DONE;
			end
			ST_SWEEP: begin
				ram_raddr = sw_addr_q;
				if (sw_issue_q) begin
					sw_v_d = 1'b1;
					if (sw_addr_q == LAST_IDX) begin
						sw_issue_d = 1'b0;
					end else begin
						sw_addr_d = sw_addr_q + 1'b1;
					end
				end
				// one entry back from the table per cycle: drop it if idle too long
				if (sw_v_s1) begin
					if (expire) begin
						ram_we    = 1'b1;
						ram_waddr = sw_addr_s1;
					end
					if (sw_addr_s1 == idx_q) begin
						res_d.active_connections = expire ? '0 : rd_ent.connections;
					end
					if (sw_addr_s1 == LAST_IDX) begin
						sw_addr_d = '0;
						state_d   = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (cfg.global_burst_wr) begin
			gtok_d = cfg.global_burst_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			seconds_q  <= '0;
			gtok_q     <= RST_GLOBAL_BURST;
			glast_q    <= '0;
			sw_addr_q  <= '0;
			sw_issue_q <= 1'b0;
			sw_v_s1    <= 1'b0;
		end else begin
			state_q    <= state_d;
			seconds_q  <= seconds_d;
			gtok_q     <= gtok_d;
			glast_q    <= glast_d;
			sw_addr_q  <= sw_addr_d;
			sw_issue_q <= sw_issue_d;
			sw_v_s1    <= sw_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q     <= cmd.command;
			idx_q     <= idx_in;
			rate_q    <= cmd.use_default ? cfg.default_rate : cmd.req_rate;
			burst_q   <= cmd.use_default ? cfg.default_burst : cmd.req_burst;
			maxc_q    <= cmd.max_connections;
			g_prod_s1 <= g_prod;
			g_elnz_s1 <= (g_el != '0);
		end
		res_q      <= res_d;
		ent_s2     <= ent_d;
		c_prod_s2  <= c_prod_d;
		c_elnz_s2  <= c_elnz_d;
		sw_addr_s1 <= sw_addr_q;
	end
endmodule

>>> rtl/two_level_token_bucket_limiter_top.sv
`timescale 1ns / 1ps
// Top level of the two-level token bucket limiter: registers, sequencer, output stage.
//
//   port        dir   handshake       word
//   cmd         in    valid/ready     command, client index, rates, connection limit
//   rsp         out   valid/ready     allowed, status, remaining, reset time, connections
//   cfg_*       in    cfg_we only     register index and 16-bit data, no read-back
//
// Open, close and a request that passes the global bucket make one read-modify-write of
// their client table entry; tick, check and unused codes only read it. Such a request
// adds the client refill state after evaluation. Expire sweep and clear walk every entry,
// one entry per cycle through the table RAM port. After reset the table is zeroed with
// cmd.ready low. A stalled result sits in the output register while the next command is
// taken; the sequencer waits only if a second result is ready.
module two_level_token_bucket_limiter_top import tlbl_pkg::*; #(
	parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tlbl_cmd_if.sink              cmd,
	tlbl_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	cfg_t cfg;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_res_q;

	tlbl_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	tlbl_ctrl #(
		.NUM_CLIENTS(NUM_CLIENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register: load when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.allowed            = out_res_q.allowed;
	assign rsp.status             = out_res_q.status;
	assign rsp.remaining          = out_res_q.remaining;
	assign rsp.reset_after        = out_res_q.reset_after;
	assign rsp.connection_ok      = out_res_q.connection_ok;
	assign rsp.active_connections = out_res_q.active_connections;

`ifndef SYNTHESIS
	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd.ready)
		else $error("command accepted while a result is pending");

	a_result_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> rsp.valid)
		else $error("handed-over result missing from output register");

	a_allowed_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.allowed |-> rsp.status == STAT_OK)
		else $error("allowed word with a refusal status");

	a_refusal_no_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == STAT_GLOBAL || rsp.status == STAT_CLIENT)
		|-> rsp.remaining == '0)
		else $error("refused word reports remaining tokens");
`endif
endmodule
